// ===== hdl/rational_arithmetic_unit_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RAU_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define RAU_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define RAU_ASSERT_IMP(label, clk, rst, pre, post)
`define RAU_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== hdl/rau_pkg.sv =====
package rau_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DEN = 2'd1,
      STATUS_DIV_ZERO = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED,
      ST_MUL,
      ST_COMB,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_A,
      PH_B,
      PH_R
   } phase_type;

   typedef enum logic [1:0] {
      RED_IDLE,
      RED_GCD,
      RED_DIV_N,
      RED_DIV_D
   } red_state_type;

   typedef struct packed {
      logic        neg;
      logic [63:0] mag;
   } smag_type;

   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
   } red_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] num;
      logic [63:0] den;
   } red_rsp_type;

   // signed-magnitude sum, magnitudes at most 2^62
   function automatic smag_type sm_add(smag_type x, smag_type y);
      smag_type r;
      if (x.neg == y.neg) begin
         r.neg = x.neg;
         r.mag = x.mag + y.mag;
      end else if (x.mag >= y.mag) begin
         r.neg = x.neg;
         r.mag = x.mag - y.mag;
      end else begin
         r.neg = y.neg;
         r.mag = y.mag - x.mag;
      end
      if (r.mag == 64'd0) r.neg = 1'b0;
      return r;
   endfunction

endpackage

// ===== hdl/rau_reduce.sv =====
module rau_reduce (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::red_req_type red_req,
   output rau_pkg::red_rsp_type red_rsp
);
   import rau_pkg::*;

   red_state_type state_ff, state_in;
   logic [63:0]   u_ff, u_in, v_ff, v_in, g_ff, g_in;
   logic [63:0]   n_ff, n_in, d_ff, d_in, rem_ff, rem_in;
   logic [5:0]    k_ff, k_in, cnt_ff, cnt_in;
   logic          done_ff, done_in;

   logic [63:0] sub_a, sub_b, rem2, dvd;
   logic [64:0] diff;

   // shared subtractor: gcd difference or trial subtract of the divider
   assign dvd  = (state_ff == RED_DIV_N) ? n_ff : d_ff;
   assign rem2 = {rem_ff[62:0], dvd[63]};
   assign sub_a = (state_ff == RED_GCD) ? u_ff : rem2;
   assign sub_b = (state_ff == RED_GCD) ? v_ff : g_ff;
   assign diff  = {1'b0, sub_a} - {1'b0, sub_b};

   always_comb begin
      state_in = state_ff;
      u_in = u_ff; v_in = v_ff; g_in = g_ff; k_in = k_ff;
      n_in = n_ff; d_in = d_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      done_in = 1'b0;
      unique case (state_ff)
         RED_IDLE: begin
            if (red_req.start) begin
               n_in = red_req.num;
               d_in = red_req.den;
               u_in = red_req.num;
               v_in = red_req.den;
               k_in = '0;
               if (red_req.num == 64'd0) begin
                  d_in    = 64'd1;
                  done_in = 1'b1;
               end else begin
                  state_in = RED_GCD;
               end
            end
         end
         RED_GCD: begin
            if (u_ff == v_ff) begin
               g_in     = u_ff << k_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = RED_DIV_N;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 6'd1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (!diff[64]) begin
               u_in = diff[63:0];
            end else begin
               v_in = 64'(~diff[63:0] + 64'd1);
            end
         end
         RED_DIV_N, RED_DIV_D: begin
            rem_in = diff[64] ? rem2 : diff[63:0];
            cnt_in = cnt_ff + 6'd1;
            if (state_ff == RED_DIV_N) n_in = {dvd[62:0], !diff[64]};
            else                       d_in = {dvd[62:0], !diff[64]};
            if (cnt_ff == 6'd63) begin
               rem_in = '0;
               cnt_in = '0;
               if (state_ff == RED_DIV_N) begin
                  state_in = RED_DIV_D;
               end else begin
                  done_in  = 1'b1;
                  state_in = RED_IDLE;
               end
            end
         end
         default: state_in = RED_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RED_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in; v_ff <= v_in; g_ff <= g_in; k_ff <= k_in;
      n_ff <= n_in; d_ff <= d_in; rem_ff <= rem_in;
   end

   assign red_rsp.done = done_ff;
   assign red_rsp.num  = n_ff;
   assign red_rsp.den  = d_ff;

endmodule

// ===== hdl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: one request at a time. Each operand is reduced by
// a binary gcd followed by two 64-step restoring divisions, the four cross
// products come from one 32x32 multiplier in turn, and the result goes
// through the same gcd and divide engine again. Most of a request's time is
// spent in the gcd/divide engine, whose gcd steps depend on the operand bits.
// A zero numerator makes its reduction nearly free, and a zero input
// denominator skips the reductions and goes straight to the output state.
// A finished response waits in the output register while the next request
// is taken.
`include "rational_arithmetic_unit_macros.svh"
module rational_arithmetic_unit #(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_a_num,
   input  logic [31:0] req_a_den,
   input  logic [31:0] req_b_num,
   input  logic [31:0] req_b_den,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_res_num,
   output logic [30:0] rsp_res_den,
   output logic        rsp_a_less_b,
   output logic        rsp_a_equal_b,
   output logic [1:0]  rsp_status
);
   import rau_pkg::*;

   localparam int EW = (WIDTH > 32) ? 32 : WIDTH;
   localparam logic [63:0] LIM = 64'd1 << (EW - 1);

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [1:0]  mstep_ff, mstep_in;
   op_type      op_ff, op_in;
   logic        an_neg_ff, an_neg_in, bn_neg_ff, bn_neg_in, rn_neg_ff, rn_neg_in;
   logic [31:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [63:0] x_ff, x_in, y_ff, y_in, z_ff, z_in, rd_ff, rd_in;
   logic        less_ff, less_in, equal_ff, equal_in;
   status_type  status_ff, status_in;
   logic [31:0] num_ff, num_in;
   logic [30:0] den_ff, den_in;
   red_req_type red_req_ff, red_req_in;
   red_rsp_type red_rsp;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] o_num_ff, o_num_in;
   logic [30:0] o_den_ff, o_den_in;
   logic        o_less_ff, o_less_in, o_equal_ff, o_equal_in;
   status_type  o_status_ff, o_status_in;

   logic [31:0] mul_a, mul_b, a_nm, a_dm, b_nm, b_dm;
   logic [63:0] prod;
   smag_type    cmp_x, cmp_y, cmp_d, sum_y, sum_r;
   logic        ovf;

   rau_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .red_req (red_req_ff),
      .red_rsp (red_rsp)
   );

   assign a_nm = req_a_num[31] ? 32'(~req_a_num + 32'd1) : req_a_num;
   assign a_dm = req_a_den[31] ? 32'(~req_a_den + 32'd1) : req_a_den;
   assign b_nm = req_b_num[31] ? 32'(~req_b_num + 32'd1) : req_b_num;
   assign b_dm = req_b_den[31] ? 32'(~req_b_den + 32'd1) : req_b_den;

   always_comb begin
      case (mstep_ff)
         2'd0: begin mul_a = an_ff; mul_b = bd_ff; end
         2'd1: begin mul_a = bn_ff; mul_b = ad_ff; end
         2'd2: begin mul_a = ad_ff; mul_b = (op_ff == OP_DIV) ? bn_ff : bd_ff; end
         default: begin mul_a = an_ff; mul_b = (op_ff == OP_MUL) ? bn_ff : bd_ff; end
      endcase
   end
   assign prod = 64'(mul_a) * 64'(mul_b);

   assign cmp_x = '{neg: an_neg_ff, mag: x_ff};
   assign cmp_y = '{neg: !bn_neg_ff && (y_ff != 64'd0), mag: y_ff};
   assign cmp_d = sm_add(cmp_x, cmp_y);
   assign sum_y = '{neg: ((op_ff == OP_SUB) ? !bn_neg_ff : bn_neg_ff) && (y_ff != 64'd0),
                    mag: y_ff};
   assign sum_r = sm_add(cmp_x, sum_y);

   assign ovf = (red_rsp.num > (rn_neg_ff ? LIM : LIM - 64'd1)) ||
                (red_rsp.den > LIM - 64'd1);

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; mstep_in = mstep_ff; op_in = op_ff;
      an_neg_in = an_neg_ff; bn_neg_in = bn_neg_ff; rn_neg_in = rn_neg_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; rd_in = rd_ff;
      less_in = less_ff; equal_in = equal_ff; status_in = status_ff;
      num_in = num_ff; den_in = den_ff;
      red_req_in = red_req_ff;
      red_req_in.start = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_num_in = o_num_ff; o_den_in = o_den_ff; o_less_in = o_less_ff;
      o_equal_in = o_equal_ff; o_status_in = o_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = op_type'(req_op);
               an_in = a_nm; ad_in = a_dm; bn_in = b_nm; bd_in = b_dm;
               an_neg_in = (req_a_num[31] ^ req_a_den[31]) && (a_nm != 32'd0);
               bn_neg_in = (req_b_num[31] ^ req_b_den[31]) && (b_nm != 32'd0);
               less_in = 1'b0; equal_in = 1'b0;
               num_in = '0; den_in = '0;
               if (a_dm == 32'd0 || b_dm == 32'd0) begin
                  status_in = STATUS_ZERO_DEN;
                  state_in  = ST_OUT;
               end else begin
                  status_in  = STATUS_OK;
                  red_req_in = '{start: 1'b1, num: 64'(a_nm), den: 64'(a_dm)};
                  phase_in   = PH_A;
                  state_in   = ST_RED;
               end
            end
         end
         ST_RED: begin
            if (red_rsp.done) begin
               unique case (phase_ff)
                  PH_A: begin
                     an_in = red_rsp.num[31:0];
                     ad_in = red_rsp.den[31:0];
                     if (red_rsp.num == 64'd0) an_neg_in = 1'b0;
                     red_req_in = '{start: 1'b1, num: 64'(bn_ff), den: 64'(bd_ff)};
                     phase_in   = PH_B;
                  end
                  PH_B: begin
                     bn_in = red_rsp.num[31:0];
                     bd_in = red_rsp.den[31:0];
                     if (red_rsp.num == 64'd0) bn_neg_in = 1'b0;
                     mstep_in = '0;
                     state_in = ST_MUL;
                  end
                  default: begin
                     if (ovf) begin
                        status_in = STATUS_OVERFLOW;
                     end else begin
                        num_in = rn_neg_ff ? 32'(~red_rsp.num[31:0] + 32'd1)
                                           : red_rsp.num[31:0];
                        den_in = red_rsp.den[30:0];
                     end
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_MUL: begin
            mstep_in = mstep_ff + 2'd1;
            case (mstep_ff)
               2'd0:    x_in  = prod;
               2'd1:    y_in  = prod;
               2'd2:    rd_in = prod;
               default: begin
                  z_in     = prod;
                  state_in = ST_COMB;
               end
            endcase
         end
         ST_COMB: begin
            less_in  = cmp_d.neg && (cmp_d.mag != 64'd0);
            equal_in = (cmp_d.mag == 64'd0);
            if (op_ff == OP_DIV && bn_ff == 32'd0) begin
               status_in = STATUS_DIV_ZERO;
               state_in  = ST_OUT;
            end else begin
               if (op_ff == OP_ADD || op_ff == OP_SUB) begin
                  rn_neg_in  = sum_r.neg;
                  red_req_in = '{start: 1'b1, num: sum_r.mag, den: rd_ff};
               end else begin
                  rn_neg_in  = (an_neg_ff ^ bn_neg_ff) && (z_ff != 64'd0);
                  red_req_in = '{start: 1'b1, num: z_ff, den: rd_ff};
               end
               phase_in = PH_R;
               state_in = ST_RED;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_num_in = num_ff; o_den_in = den_ff;
               o_less_in = less_ff; o_equal_in = equal_ff; o_status_in = status_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_A;
         mstep_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         red_req_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         mstep_ff      <= mstep_in;
         rsp_valid_ff  <= rsp_valid_in;
         red_req_ff    <= red_req_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      an_neg_ff <= an_neg_in; bn_neg_ff <= bn_neg_in; rn_neg_ff <= rn_neg_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; rd_ff <= rd_in;
      less_ff <= less_in; equal_ff <= equal_in; status_ff <= status_in;
      num_ff <= num_in; den_ff <= den_in;
      o_num_ff <= o_num_in; o_den_ff <= o_den_in; o_less_ff <= o_less_in;
      o_equal_ff <= o_equal_in; o_status_ff <= o_status_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res_num   = o_num_ff;
   assign rsp_res_den   = o_den_ff;
   assign rsp_a_less_b  = o_less_ff;
   assign rsp_a_equal_b = o_equal_ff;
   assign rsp_status    = o_status_ff;

   `RAU_ASSERT_IMP(flags_exclusive, clock, reset, rsp_valid_ff, !(o_less_ff && o_equal_ff))
   `RAU_ASSERT_IMP(bad_status_zero, clock, reset, rsp_valid_ff && o_status_ff != STATUS_OK, o_num_ff == 32'd0 && o_den_ff == 31'd0)
   `RAU_ASSERT_IMP(ok_den_nonzero, clock, reset, rsp_valid_ff && o_status_ff == STATUS_OK, o_den_ff != 31'd0)
   `RAU_ASSERT_IMP(reduce_done_in_red, clock, reset, red_rsp.done, state_ff == ST_RED)
   `RAU_ASSERT_NEXT(busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

endmodule

// ===== tb/sv/rational_arithmetic_unit_test.sv =====
module rational_arithmetic_unit_test;
   import rau_pkg::*;

   localparam int RESULT_BITS = 32;

   typedef struct {
      bit              neg;
      longint unsigned mag;
   } signed_mag_t;

   typedef struct {
      logic [31:0] res_num;
      logic [30:0] res_den;
      logic        a_less_b;
      logic        a_equal_b;
      status_type  status;
   } fraction_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = 2'd0;
   logic [31:0] req_a_num = '0;
   logic [31:0] req_a_den = 32'd1;
   logic [31:0] req_b_num = '0;
   logic [31:0] req_b_den = 32'd1;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_res_num;
   logic [30:0] rsp_res_den;
   logic        rsp_a_less_b;
   logic        rsp_a_equal_b;
   logic [1:0]  rsp_status;

   fraction_result_t pending_results[$];
   int mismatches = 0;
   int unexpected = 0;
   int checked = 0;
   int status_seen[4] = '{0, 0, 0, 0};
   int sent = 0;
   int stall_left = 0;

   rational_arithmetic_unit #(.WIDTH(RESULT_BITS)) dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic signed_mag_t unpack_field(logic [31:0] v);
      signed_mag_t r;
      r.neg = v[31];
      r.mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
      return r;
   endfunction

   function automatic signed_mag_t signed_sum(signed_mag_t x, signed_mag_t y);
      signed_mag_t r;
      if (x.neg == y.neg) begin
         r.neg = x.neg;
         r.mag = x.mag + y.mag;
      end else if (x.mag >= y.mag) begin
         r.neg = x.neg;
         r.mag = x.mag - y.mag;
      end else begin
         r.neg = y.neg;
         r.mag = y.mag - x.mag;
      end
      if (r.mag == 0) r.neg = 1'b0;
      return r;
   endfunction

   function automatic longint unsigned gcd(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic void lowest_terms(inout signed_mag_t n, inout longint unsigned d);
      longint unsigned g;
      g = gcd(n.mag, d);
      if (g == 0) g = 1;
      n.mag = n.mag / g;
      d = d / g;
      if (n.mag == 0) begin
         n.neg = 1'b0;
         d = 1;
      end
   endfunction

   function automatic fraction_result_t compute_fraction(op_type op, logic [31:0] a_num,
         logic [31:0] a_den, logic [31:0] b_num, logic [31:0] b_den);
      fraction_result_t r;
      signed_mag_t an, ad, bn, bd, x, y, diff, rn;
      longint unsigned adm, bdm, rd, lim;
      r = '{default: '0, status: STATUS_OK};
      an = unpack_field(a_num);
      ad = unpack_field(a_den);
      bn = unpack_field(b_num);
      bd = unpack_field(b_den);
      lim = 64'd1 << (RESULT_BITS - 1);
      if (ad.mag == 0 || bd.mag == 0) begin
         r.status = STATUS_ZERO_DEN;
         return r;
      end
      if (ad.neg) an.neg = !an.neg;
      if (bd.neg) bn.neg = !bn.neg;
      if (an.mag == 0) an.neg = 1'b0;
      if (bn.mag == 0) bn.neg = 1'b0;
      adm = ad.mag;
      bdm = bd.mag;
      lowest_terms(an, adm);
      lowest_terms(bn, bdm);
      // compare by the sign of the cross difference
      x = '{an.neg, an.mag * bdm};
      y = '{!bn.neg, bn.mag * adm};
      if (y.mag == 0) y.neg = 1'b0;
      diff = signed_sum(x, y);
      r.a_less_b = diff.neg && diff.mag != 0;
      r.a_equal_b = diff.mag == 0;
      case (op)
         OP_ADD, OP_SUB: begin
            y = '{(op == OP_SUB) ? !bn.neg : bn.neg, bn.mag * adm};
            if (y.mag == 0) y.neg = 1'b0;
            rn = signed_sum(x, y);
            rd = adm * bdm;
         end
         OP_MUL: begin
            rn = '{an.neg != bn.neg, an.mag * bn.mag};
            rd = adm * bdm;
         end
         default: begin
            if (bn.mag == 0) begin
               r.status = STATUS_DIV_ZERO;
               return r;
            end
            rn = '{an.neg != bn.neg, an.mag * bdm};
            rd = adm * bn.mag;
         end
      endcase
      if (rn.mag == 0) rn.neg = 1'b0;
      lowest_terms(rn, rd);
      if (rn.mag > (rn.neg ? lim : lim - 1) || rd > lim - 1) begin
         r.status = STATUS_OVERFLOW;
      end else begin
         r.res_num = rn.neg ? 32'(0 - rn.mag) : 32'(rn.mag);
         r.res_den = 31'(rd);
      end
      return r;
   endfunction

   // hold the request until the block takes it; valid stays high for the caller
   task automatic send_request(op_type op, logic [31:0] a_num, logic [31:0] a_den,
         logic [31:0] b_num, logic [31:0] b_den);
      pending_results.push_back(compute_fraction(op, a_num, a_den, b_num, b_den));
      req_valid <= 1'b1;
      req_op <= op;
      req_a_num <= a_num;
      req_a_den <= a_den;
      req_b_num <= b_num;
      req_b_den <= b_den;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic sender_gap();
      int n;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) n = 0;
      else if (pick < 93) n = $urandom_range(1, 4);
      else n = $urandom_range(20, 80);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_value();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return 32'($signed($urandom_range(0, 40)) - 20);
      if (pick < 65) return 32'($signed($urandom_range(0, 65536)) - 32768);
      if (pick < 90) return $urandom;
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'd1;
         default: return 32'd0;
      endcase
   endfunction

   function automatic logic [31:0] random_denominator();
      logic [31:0] v;
      if ($urandom_range(0, 99) < 3) return 32'd0;
      v = random_value();
      return (v == 0) ? 32'd1 : v;
   endfunction

   task automatic test_operations();
      send_request(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
      send_request(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd3);
      send_request(OP_MUL, 32'd6, 32'd4, -32'sd2, 32'd9);
      send_request(OP_DIV, 32'd3, 32'd7, 32'd5, -32'sd14);
      send_request(OP_SUB, 32'd5, 32'd10, 32'd1, 32'd2);
      send_request(OP_ADD, 32'd0, 32'd5, 32'd0, -32'sd7);
      send_request(OP_MUL, 32'd0, -32'sd3, 32'd4, 32'd9);
   endtask

   task automatic test_special_cases();
      send_request(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
      send_request(OP_DIV, 32'd1, 32'd1, 32'd1, 32'd0);
      send_request(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
      send_request(OP_MUL, 32'd0, 32'd0, 32'd0, 32'd0);
      send_request(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
      send_request(OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
      send_request(OP_SUB, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
      send_request(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(OP_DIV, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
      send_request(OP_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
      send_request(OP_ADD, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE);
      send_request(OP_DIV, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2, 32'd2);
      req_valid <= 1'b0;
   endtask

   // hold off new requests until every response is back
   task automatic test_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
      send_request(OP_DIV, 32'd7, 32'd3, -32'sd7, 32'd3);
   endtask

   task automatic test_random_mix(int count);
      for (int i = 0; i < count; i++) begin
         send_request(op_type'($urandom_range(0, 3)), random_value(), random_denominator(),
                      random_value(), random_denominator());
         sender_gap();
      end
      req_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               rsp_stall <= 1'b0;
               stall_left <= $urandom_range(0, 40);
            end
            9: begin
               rsp_stall <= 1'b1;
               stall_left <= $urandom_range(50, 300);
            end
            default: begin
               rsp_stall <= 1'b1;
               stall_left <= $urandom_range(0, 3);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      fraction_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("response with no request outstanding: num %h den %h status %0d",
                        rsp_res_num, rsp_res_den, rsp_status);
         end else begin
            want = pending_results.pop_front();
            checked++;
            status_seen[want.status]++;
            if (rsp_res_num !== want.res_num || rsp_res_den !== want.res_den ||
                rsp_a_less_b !== want.a_less_b || rsp_a_equal_b !== want.a_equal_b ||
                rsp_status !== want.status) begin
               mismatches++;
               if (mismatches + unexpected <= 10)
                  $display("mismatch: expected %h/%h lt %b eq %b st %0d, got %h/%h lt %b eq %b st %0d",
                           want.res_num, want.res_den, want.a_less_b, want.a_equal_b,
                           want.status, rsp_res_num, rsp_res_den, rsp_a_less_b,
                           rsp_a_equal_b, rsp_status);
            end
         end
      end
   end

   initial begin
      #(12 * 6000000);
      $display("[rational_arithmetic_unit] ERROR");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_operations();
      test_special_cases();
      test_random_mix(450);
      test_drain();
      test_random_mix(450);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      $display("checked %0d responses for %0d requests: %0d ok, %0d zero denominator,",
               checked, sent, status_seen[0], status_seen[1]);
      $display("%0d division by zero, %0d overflow", status_seen[2], status_seen[3]);
      if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0)
         $display("[rational_arithmetic_unit] OK");
      else
         $display("[rational_arithmetic_unit] ERROR");
      $finish;
   end

endmodule

// ===== rational_arithmetic_unit.f =====
+incdir+hdl
hdl/rau_pkg.sv
hdl/rau_reduce.sv
hdl/rational_arithmetic_unit.sv
tb/sv/rational_arithmetic_unit_test.sv
